// ===== hw/rtl/lnfr_pkg.sv =====
// Package for the length nibble frame receiver.
// Holds the byte kind codes and field widths; depends on nothing.
`default_nettype none

package lnfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned NibW   = 4;

  localparam logic [NibW-1:0] NibbleExt = 4'hF;

  typedef enum logic [KindW-1:0] {
    KindOpcode = 2'd0,
    KindLength = 2'd1,
    KindData   = 2'd2,
    KindCheck  = 2'd3
  } kind_e;

endpackage

`default_nettype wire

// ===== hw/rtl/length_nibble_frame_receiver.sv =====
// Length nibble frame receiver: splits a byte stream into frames and checks their XOR sum.
// Top level; depends on lnfr_pkg.
//
// One beat in, one beat out, at one beat per clock cycle while the output is not stalled.
// A beat is taken into an input register, classified by the frame state in a single step,
// and placed in an output register. Both registers advance whenever the output register
// is empty or being taken, so s_axis_tready_o follows m_axis_tready_i combinationally and
// a stalled output still leaves room for one more beat. Each frame is an opcode byte whose
// low nibble is the data length (15 means an extended length byte follows), the data
// bytes, and a checksum byte equal to the XOR of all earlier bytes of the frame. A checksum
// mismatch is reported on the closing beat and the next byte is taken as a new opcode.
`default_nettype none

module length_nibble_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] frame_byte, [15:8] data_index
  output logic             m_axis_tlast_o,   // frame_end
  output logic [2:0]       m_axis_tuser_o    // [1:0] byte_kind, [2] checksum_ok
);

  import lnfr_pkg::*;

  typedef enum logic [1:0] {
    PhOpcode = 2'd0,
    PhLength = 2'd1,
    PhData   = 2'd2,
    PhCheck  = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [ByteW-1:0]  cnt_inc;

  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q;
  logic [ByteW-1:0]  out_byte_q;
  logic [ByteW-1:0]  out_idx_q;
  kind_e             out_kind_q;
  logic              out_end_q;
  logic              out_ok_q;

  logic              advance;
  logic              in_load;
  logic [NibW-1:0]   nib;
  kind_e             kind;
  logic [ByteW-1:0]  idx;
  logic              fend;
  logic              ok;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;
  assign nib             = in_byte_q[NibW-1:0];
  assign cnt_inc         = cnt_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    kind    = KindOpcode;
    idx     = '0;
    fend    = 1'b0;
    ok      = 1'b0;
    case (phase_q)
      PhOpcode: begin
        kind  = KindOpcode;
        xor_d = in_byte_q;
        cnt_d = '0;
        if (nib == NibbleExt) begin
          len_d   = '0;
          phase_d = PhLength;
        end else begin
          len_d   = {{(ByteW-NibW){1'b0}}, nib};
          phase_d = (nib == '0) ? PhCheck : PhData;
        end
      end
      PhLength: begin
        kind    = KindLength;
        xor_d   = xor_q ^ in_byte_q;
        len_d   = in_byte_q;
        cnt_d   = '0;
        phase_d = (in_byte_q == '0) ? PhCheck : PhData;
      end
      PhData: begin
        kind  = KindData;
        xor_d = xor_q ^ in_byte_q;
        idx   = cnt_q;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        kind    = KindCheck;
        fend    = 1'b1;
        ok      = (in_byte_q == xor_q);
        phase_d = PhOpcode;
        len_d   = '0;
        cnt_d   = '0;
        xor_d   = '0;
      end
      default: begin
        phase_d = PhOpcode;
        len_d   = '0;
        cnt_d   = '0;
        xor_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhOpcode;
      len_q       <= '0;
      cnt_q       <= '0;
      xor_q       <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q     <= phase_d;
        len_q       <= len_d;
        cnt_q       <= cnt_d;
        xor_q       <= xor_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_byte_q <= in_byte_q;
      out_idx_q  <= idx;
      out_kind_q <= kind;
      out_end_q  <= fend;
      out_ok_q   <= ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_idx_q, out_byte_q};
  assign m_axis_tlast_o  = out_end_q;
  assign m_axis_tuser_o  = {out_ok_q, out_kind_q};

`ifndef SYNTHESIS
  a_end_is_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o[1:0] == KindCheck)))
    else $error("frame end not on checksum beat");

  a_ok_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2]) |-> m_axis_tlast_o)
    else $error("checksum ok outside frame end");

  a_index_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[15:8] != 8'd0)) |->
      (m_axis_tuser_o[1:0] == KindData))
    else $error("data index on non-data beat");

  a_check_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PhCheck) |=> (phase_q == PhOpcode && xor_q == '0 && cnt_q == '0))
    else $error("state not cleared after checksum beat");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for length_nibble_frame_receiver: directed frame table, then random
// frames, bad checksums and noise bytes, checked beat by beat against a deframing predictor.
// Depends on lnfr_pkg and the length_nibble_frame_receiver RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lnfr_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned PhaseBeats = 234;

  typedef enum logic [1:0] {
    WaitOpcode,
    WaitLength,
    InData,
    WaitCheck
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    kind_e      kind;
    logic [7:0] data_index;
    logic       frame_end;
    logic       checksum_ok;
  } beat_result_t;

  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    beat_result_t want;
  } stim_row_t;

  localparam stim_row_t DirectedRows [24] = '{
    '{8'h00, 1'b1, '{8'h00, KindOpcode, 8'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, KindCheck,  8'd0, 1'b1, 1'b1}},
    '{8'hFF, 1'b1, '{8'hFF, KindOpcode, 8'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, KindLength, 8'd0, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, '{8'hFF, KindCheck,  8'd0, 1'b1, 1'b1}},
    '{8'h11, 1'b1, '{8'h11, KindOpcode, 8'd0, 1'b0, 1'b0}},
    '{8'hAA, 1'b1, '{8'hAA, KindData,   8'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, KindCheck,  8'd0, 1'b1, 1'b0}},
    '{8'h03, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'hFD, 1'b0, '0},
    '{8'hEF, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h0F, 1'b1, '{8'h0F, KindOpcode, 8'd0, 1'b0, 1'b0}},
    '{8'h01, 1'b1, '{8'h01, KindLength, 8'd0, 1'b0, 1'b0}},
    '{8'h55, 1'b1, '{8'h55, KindData,   8'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{8'h00, KindCheck,  8'd0, 1'b1, 1'b0}},
    '{8'hF0, 1'b1, '{8'hF0, KindOpcode, 8'd0, 1'b0, 1'b0}},
    '{8'hF0, 1'b1, '{8'hF0, KindCheck,  8'd0, 1'b1, 1'b1}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [2:0]  m_axis_tuser_o;

  rx_phase_e    rx_phase = WaitOpcode;
  logic [7:0]   frame_len = 8'd0;
  logic [7:0]   data_seen = 8'd0;
  logic [7:0]   frame_xor = 8'd0;
  beat_result_t pending_beats[$];
  beat_result_t want;
  int unsigned  mismatch_cnt = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  sent_cnt = 0;
  int unsigned  src_idle_pct = 16;
  int unsigned  sink_idle_pct = 73;

  length_nibble_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic beat_result_t deframe_byte(logic [7:0] b);
    beat_result_t r;
    r = '{b, KindOpcode, 8'd0, 1'b0, 1'b0};
    case (rx_phase)
      WaitOpcode: begin
        frame_xor = b;
        data_seen = 8'd0;
        if (b[3:0] == NibbleExt) begin
          frame_len = 8'd0;
          rx_phase  = WaitLength;
        end else begin
          frame_len = {4'd0, b[3:0]};
          rx_phase  = (b[3:0] == 4'd0) ? WaitCheck : InData;
        end
      end
      WaitLength: begin
        r.kind    = KindLength;
        frame_xor = frame_xor ^ b;
        frame_len = b;
        data_seen = 8'd0;
        rx_phase  = (b == 8'd0) ? WaitCheck : InData;
      end
      InData: begin
        r.kind       = KindData;
        r.data_index = data_seen;
        frame_xor    = frame_xor ^ b;
        data_seen    = data_seen + 8'd1;
        if (data_seen >= frame_len) rx_phase = WaitCheck;
      end
      default: begin
        r.kind        = KindCheck;
        r.frame_end   = 1'b1;
        r.checksum_ok = (b == frame_xor);
        rx_phase      = WaitOpcode;
        frame_len     = 8'd0;
        data_seen     = 8'd0;
        frame_xor     = 8'd0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 50) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic send_beat(logic [7:0] b, logic typed, beat_result_t typed_want);
    beat_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = deframe_byte(b);
    pending_beats.push_back(typed ? typed_want : r);
    sent_cnt++;
  endtask

  task automatic send_frame(int unsigned len, logic ext, logic corrupt);
    logic [7:0] opc;
    logic [7:0] sum;
    logic [7:0] d;
    opc = {4'($urandom_range(15)), ext ? NibbleExt : 4'(len)};
    sum = opc;
    send_beat(opc, 1'b0, '0);
    if (ext) begin
      send_beat(8'(len), 1'b0, '0);
      sum = sum ^ 8'(len);
    end
    repeat (len) begin
      d   = 8'($urandom);
      sum = sum ^ d;
      send_beat(d, 1'b0, '0);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(255, 1));
    send_beat(sum, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", m_axis_tdata_o));
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata_o[7:0] != want.frame_byte)
          report_mismatch($sformatf("frame_byte %h, want %h", m_axis_tdata_o[7:0],
                                    want.frame_byte));
        if (m_axis_tuser_o[1:0] != want.kind)
          report_mismatch($sformatf("byte_kind %0d, want %0d", m_axis_tuser_o[1:0], want.kind));
        if (m_axis_tdata_o[15:8] != want.data_index)
          report_mismatch($sformatf("data_index %0d, want %0d", m_axis_tdata_o[15:8],
                                    want.data_index));
        if (m_axis_tlast_o != want.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b", m_axis_tlast_o, want.frame_end));
        if (m_axis_tuser_o[2] != want.checksum_ok)
          report_mismatch($sformatf("checksum_ok %b, want %b", m_axis_tuser_o[2],
                                    want.checksum_ok));
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned start;
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedRows[i]) send_beat(DirectedRows[i].rx, DirectedRows[i].typed,
                                        DirectedRows[i].want);
    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 16 : (ph == 1) ? 73 : 0;
      sink_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 16 : 0;
      start = sent_cnt;
      if (ph == 1) send_frame(255, 1'b1, 1'b0);
      while (sent_cnt - start < PhaseBeats) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame($urandom_range(14), 1'b0, 1'b0);
        end else if (pick < 82) begin
          send_frame($urandom_range(40), 1'b1, 1'b0);
        end else if (pick < 92) begin
          if ($urandom_range(1)) send_frame($urandom_range(40), 1'b1, 1'b1);
          else send_frame($urandom_range(14), 1'b0, 1'b1);
        end else begin
          repeat ($urandom_range(4, 1)) send_beat(8'($urandom), 1'b0, '0);
          while (rx_phase != WaitOpcode) send_beat(8'($urandom), 1'b0, '0);
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_beats.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", pending_beats.size()));
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
